// ----- hw/rtl/dq_pkg.sv -----
// Shared request/status codes, defaults and control structs for the deque.
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 8;

  localparam int REQ_W = 3;
  localparam int ST_W  = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic take;   // latch the incoming request and update head/count/store
    logic load;   // move the read ends into the output register
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } dq_sts_t;

endpackage

// ----- hw/rtl/double_ended_queue_top.sv -----
// Double-ended queue top level: stream ports, sequencer and datapath.
//
//  channel | dir | tdata (low bit up)                 | tuser (low bit up)
//  --------+-----+------------------------------------+---------------------------
//  in_     | in  | value                              | req_type
//  out_    | out | count, front_value, back_value     | status, ends_valid
//
// Each request goes through three steps: accept, store read, result load; the store
// read is registered, and no new request is taken until the result load is done.
// Reset (rst_n low, synchronous) empties the queue; store contents are not cleared.
// A result waits in the output register; the next request is accepted meanwhile,
// and its result load holds until the register is taken.
module double_ended_queue_top #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]        in_tdata,   // value
  input  logic [dq_pkg::REQ_W-1:0]               in_tuser,   // req_type
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // count, front_value, back_value
  output logic [(($clog2(DEPTH+1)+2*DATA_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic [dq_pkg::ST_W:0]                  out_tuser   // status, ends_valid
);
  import dq_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OUT_W = ((CW + 2 * DATA_WIDTH + 7) / 8) * 8;

  dq_cmd_t cmd;
  dq_sts_t sts;

  logic [ST_W-1:0]       status;
  logic [CW-1:0]         count;
  logic                  ends_valid;
  logic [DATA_WIDTH-1:0] front_value, back_value;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dq_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (in_tuser),
    .value          (in_tdata[DATA_WIDTH-1:0]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (status),
    .out_count      (count),
    .out_ends_valid (ends_valid),
    .out_front      (front_value),
    .out_back       (back_value)
  );

  assign out_tdata = OUT_W'({back_value, front_value, count});
  assign out_tuser = {ends_valid, status};

endmodule

// ----- hw/rtl/dq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/dq_ctrl.sv -----
// Request sequencer: accept, read both ends, load the result register.
module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output dq_pkg::dq_cmd_t cmd,
  input  dq_pkg::dq_sts_t sts
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign cmd.take  = in_tvalid && in_tready;
  assign cmd.load  = (state_r == S_LOAD) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.take) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        if (cmd.load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/dq_datapath.sv -----
// Head/count registers, circular entry store and result register.
module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dq_pkg::dq_cmd_t             cmd,
  output dq_pkg::dq_sts_t             sts,
  input  logic [dq_pkg::REQ_W-1:0]    req_type,
  input  logic [DATA_WIDTH-1:0]       value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dq_pkg::ST_W-1:0]     out_status,
  output logic [$clog2(DEPTH+1)-1:0]  out_count,
  output logic                        out_ends_valid,
  output logic [DATA_WIDTH-1:0]       out_front,
  output logic [DATA_WIDTH-1:0]       out_back
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [ST_W-1:0] st_r, st_nxt;

  logic            full, empty;
  logic [SW-1:0]   tail_sum, back_sum;
  logic [SW-1:0]   tail_wrap, back_wrap;
  logic [AW-1:0]   head_dec, head_inc;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [DATA_WIDTH-1:0] rd_front, rd_back;

  logic                  out_valid_r;
  logic [ST_W-1:0]       out_status_r;
  logic [CW-1:0]         out_count_r;
  logic                  out_ends_r;
  logic [DATA_WIDTH-1:0] out_front_r, out_back_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // head + count and head + count - 1 (non-empty only), folded once into [0, DEPTH)
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign back_sum  = tail_sum - SW'(1);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
  assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    st_nxt    = ST_DONE;
    wr_en     = 1'b0;
    wr_addr   = tail_wrap[AW-1:0];
    case (req_type)
      REQ_PUSH_BACK: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.take;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          wr_en     = cmd.take;
          wr_addr   = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          st_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.take) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) st_r <= st_nxt;
  end

  // two copies of the store so front and back read in the same cycle
  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_front (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (head_r),
    .rd_data (rd_front)
  );

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_back (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (back_wrap[AW-1:0]),
    .rd_data (rd_back)
  );

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= st_r;
      out_count_r  <= count_r;
      out_ends_r   <= !empty;
      out_front_r  <= empty ? '0 : rd_front;
      out_back_r   <= empty ? '0 : rd_back;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;
  assign out_ends_valid = out_ends_r;
  assign out_front      = out_front_r;
  assign out_back       = out_back_r;

endmodule

// ----- tb/dq_result_checker.sv -----
// Result checker for the deque: watches both streams, predicts each result and compares.
`timescale 1ns / 100ps

module dq_result_checker #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1),
  parameter int IN_W       = ((DATA_WIDTH + 7) / 8) * 8,
  parameter int OUT_W      = ((CNT_W + 2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [IN_W-1:0]          in_tdata,
  input  logic [dq_pkg::REQ_W-1:0] in_tuser,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [OUT_W-1:0]         out_tdata,
  input  logic [dq_pkg::ST_W:0]    out_tuser,
  output int                       fail_count,
  output int                       pending_count,
  output int                       checked_count
);
  import dq_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]       status;
    logic [CNT_W-1:0]      count;
    logic                  ends_valid;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;
  } dq_result_t;

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int                    head_slot;
  int                    held;
  dq_result_t            pending_results [$];

  // Applies one request to the shadow deque and returns the result it should produce.
  function automatic dq_result_t predict_request(logic [REQ_W-1:0] req,
                                                 logic [DATA_WIDTH-1:0] val);
    dq_result_t res;
    res = '0;
    res.status = ST_DONE;
    case (req)
      REQ_PUSH_BACK: begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slots[(head_slot + held) % DEPTH] = val;
          held++;
        end
      end
      REQ_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slots[head_slot] = val;
          held++;
        end
      end
      REQ_POP_FRONT: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          head_slot = (head_slot + 1) % DEPTH;
          held--;
        end
      end
      REQ_POP_BACK: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held--;
        end
      end
      REQ_CLEAR: begin
        held = 0;
        head_slot = 0;
      end
      default: ;  // undefined request codes leave the deque alone
    endcase
    res.count = held[CNT_W-1:0];
    if (held > 0) begin
      res.ends_valid  = 1'b1;
      res.front_value = slots[head_slot];
      res.back_value  = slots[(head_slot + held - 1) % DEPTH];
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    dq_result_t exp;
    if (!rst_n) begin
      head_slot     = 0;
      held          = 0;
      fail_count    = 0;
      checked_count = 0;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          exp = pending_results.pop_front();
          check_field("status", exp.status, out_tuser[ST_W-1:0]);
          check_field("ends_valid", exp.ends_valid, out_tuser[ST_W]);
          check_field("count", exp.count, out_tdata[CNT_W-1:0]);
          check_field("front_value", exp.front_value,
                      out_tdata[CNT_W +: DATA_WIDTH]);
          check_field("back_value", exp.back_value,
                      out_tdata[CNT_W + DATA_WIDTH +: DATA_WIDTH]);
          checked_count++;
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_request(in_tuser, in_tdata[DATA_WIDTH-1:0]));
    end
    pending_count = pending_results.size();
  end

endmodule

// ----- tb/double_ended_queue_top_tb.sv -----
// Testbench top for the deque: clock, reset, request stimulus, output backpressure, verdict.
`timescale 1ns / 100ps

module double_ended_queue_top_tb;
  import dq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IN_W        = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_W       = ((CNT_W + 2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 446;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic [REQ_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic [ST_W:0]         out_tuser;

  int fail_count;
  int pending_count;
  int checked_count;
  int sent_total = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  double_ended_queue_top #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  dq_result_checker #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Output side: random stalls, plus one long hold-off so the deque backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved in %0d cycles", QUIET_LIMIT);
      $display("double_ended_queue_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it; returns once accepted.
  task automatic offer(logic [REQ_W-1:0] req, logic [DATA_WIDTH-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_W'(val);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_total++;
  endtask

  // Random requests in bursts that lean toward filling, draining or neither.
  task automatic run_phase(int idle_pct, int stall, int n);
    int lean;
    int push_pct;
    logic [REQ_W-1:0] req;
    logic [DATA_WIDTH-1:0] val;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) lean = $urandom_range(2);
      push_pct = (lean == 0) ? 80 : (lean == 1) ? 20 : 50;
      case ($urandom_range(99))
        0, 1:    req = REQ_CLEAR;
        2, 3:    req = REQ_W'($urandom_range(7, 5));
        default: begin
          if ($urandom_range(99) < push_pct)
            req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
          else
            req = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
      endcase
      case ($urandom_range(7))
        0:       val = '0;
        1:       val = '1;
        default: val = DATA_WIDTH'($urandom());
      endcase
      offer(req, val);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pops on empty, fill to full across the wrap, pushes on full,
    // pops at both ends, undefined codes, clear
    offer(REQ_POP_FRONT, 8'h5a);
    offer(REQ_POP_BACK, 8'ha5);
    for (int i = 0; i < DEPTH; i++)
      offer(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
            (i == 0) ? 8'h00 : (i == 1) ? 8'hff : DATA_WIDTH'(8'h11 * i));
    offer(REQ_PUSH_BACK, 8'h77);
    offer(REQ_PUSH_FRONT, 8'h88);
    offer(REQ_POP_FRONT, 8'h00);
    offer(REQ_POP_BACK, 8'hff);
    offer(REQ_W'(5), 8'h12);
    offer(REQ_W'(6), 8'h34);
    offer(REQ_W'(7), 8'h56);
    offer(REQ_CLEAR, 8'h9c);

    run_phase(0, 0, PHASE_ITEMS);

    // hold the output for a long stretch while requests keep coming
    hold_go = 1'b1;
    run_phase(0, 0, 40);

    run_phase(85, 0, PHASE_ITEMS);
    run_phase(0, 85, PHASE_ITEMS);
    run_phase(34, 34, PHASE_ITEMS);
    in_tvalid <= 1'b0;

    // let the checker count the last accepted request before waiting on it
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d requests (directed ends, fill/drain bursts, clears, undefined codes)",
             sent_total);
    $display("under four idle/stall mixes and one long output hold; %0d results checked",
             checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("double_ended_queue_top regression: pass");
    end else begin
      if (pending_count != 0) $error("%0d results never arrived", pending_count);
      $display("double_ended_queue_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue_top.f -----
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue_top.sv
tb/dq_result_checker.sv
tb/double_ended_queue_top_tb.sv
